// File: rtl/core/crll_pkg.sv
// crll_pkg: shared types, sizes and codes for the color ramp lerp lookup
// no dependencies; used by every module under rtl/core
package crll_pkg;

    localparam int RAMP_DEPTH = 256;
    localparam int ADDR_W     = $clog2(RAMP_DEPTH);
    localparam int CFG_W      = 9;
    localparam int LIFE_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int AGE_W      = FRAC_W + 1;
    localparam int POS_W      = FRAC_W + ADDR_W;
    localparam int MUL_W      = AGE_W + ADDR_W;
    localparam int COLOR_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = FRAC_W / DIV_STAGES;
    localparam int PROD_W     = CHAN_W + 1 + AGE_W;
    localparam int SUM_W      = CHAN_W + FRAC_W;
    localparam int LATENCY    = DIV_STAGES + 5;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ADDR_W:0]    nuse_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [LIFE_W-1:0]  life_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [AGE_W-1:0]   age_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [MUL_W-1:0]   mul_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_SHADE = 1'b1
    } req_t;

    localparam age_t AGE_ONE = age_t'(1) << FRAC_W;

    typedef struct packed {
        logic   shade;
        logic   wr_en;
        addr_t  addr;
        color_t color;
    } item_t;

endpackage

// File: rtl/core/crll_age_div.sv
// crll_age_div: pipelined restoring divider forming the Q1.16 particle age
// depends on crll_pkg; carries the item sideband alongside the quotient
module crll_age_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  crll_pkg::life_t     in_left,
    input  crll_pkg::life_t     in_total,
    input  crll_pkg::item_t     in_item,
    output logic                out_valid,
    output crll_pkg::age_t      out_age,
    output crll_pkg::item_t     out_item
);

    logic              vld_reg  [crll_pkg::DIV_STAGES+1];
    crll_pkg::item_t   item_reg [crll_pkg::DIV_STAGES+1];
    crll_pkg::life_t   rem_reg  [crll_pkg::DIV_STAGES+1];
    crll_pkg::frac_t   quo_reg  [crll_pkg::DIV_STAGES+1];
    crll_pkg::life_t   dvs_reg  [crll_pkg::DIV_STAGES+1];
    logic              zero_reg [crll_pkg::DIV_STAGES+1];
    logic              full_reg [crll_pkg::DIV_STAGES+1];

    crll_pkg::life_t   rem_next [crll_pkg::DIV_STAGES];
    crll_pkg::frac_t   quo_next [crll_pkg::DIV_STAGES];

    // four quotient bits (DIV_BITS) per stage
    always_comb
    begin
        logic [crll_pkg::LIFE_W:0] sh;
        crll_pkg::life_t           r;
        crll_pkg::frac_t           q;
        for (int s = 0; s < crll_pkg::DIV_STAGES; s++)
        begin
            r = rem_reg[s];
            q = quo_reg[s];
            for (int b = 0; b < crll_pkg::DIV_BITS; b++)
            begin
                sh = {r, 1'b0};
                if (sh >= {1'b0, dvs_reg[s]})
                begin
                    sh = sh - {1'b0, dvs_reg[s]};
                    q  = {q[crll_pkg::FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    q  = {q[crll_pkg::FRAC_W-2:0], 1'b0};
                end
                r = sh[crll_pkg::LIFE_W-1:0];
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= crll_pkg::DIV_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= crll_pkg::DIV_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[0] <= in_item;
        rem_reg[0]  <= in_total - in_left;
        quo_reg[0]  <= '0;
        dvs_reg[0]  <= in_total;
        zero_reg[0] <= (in_total == '0) || (in_left >= in_total);
        full_reg[0] <= (in_left == '0) && (in_total != '0);
        for (int s = 1; s <= crll_pkg::DIV_STAGES; s++)
        begin
            item_reg[s] <= item_reg[s-1];
            rem_reg[s]  <= rem_next[s-1];
            quo_reg[s]  <= quo_next[s-1];
            dvs_reg[s]  <= dvs_reg[s-1];
            zero_reg[s] <= zero_reg[s-1];
            full_reg[s] <= full_reg[s-1];
        end
    end

    always_comb
    begin
        if (full_reg[crll_pkg::DIV_STAGES])
        begin
            out_age = crll_pkg::AGE_ONE;
        end
        else if (zero_reg[crll_pkg::DIV_STAGES])
        begin
            out_age = '0;
        end
        else
        begin
            out_age = {1'b0, quo_reg[crll_pkg::DIV_STAGES]};
        end
    end

    assign out_valid = vld_reg[crll_pkg::DIV_STAGES];
    assign out_item  = item_reg[crll_pkg::DIV_STAGES];

endmodule

// File: rtl/core/crll_ramp_mem.sv
// crll_ramp_mem: ramp color memory, one write port and two registered read ports
// depends on crll_pkg for address and color types
module crll_ramp_mem (
    input  logic               clk,
    input  logic               wr_en,
    input  crll_pkg::addr_t    wr_addr,
    input  crll_pkg::color_t   wr_data,
    input  crll_pkg::addr_t    rd_addr_a,
    input  crll_pkg::addr_t    rd_addr_b,
    output crll_pkg::color_t   rd_data_a,
    output crll_pkg::color_t   rd_data_b
);

    crll_pkg::color_t mem [crll_pkg::RAMP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: rtl/core/crll_lerp.sv
// crll_lerp: two-stage per-channel linear blend of two ramp colors
// depends on crll_pkg; drives the registered result and its strobe
module crll_lerp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  crll_pkg::frac_t    in_frac,
    input  crll_pkg::color_t   in_from,
    input  crll_pkg::color_t   in_to,
    output logic               out_valid,
    output crll_pkg::chan_t    out_red,
    output crll_pkg::chan_t    out_green,
    output crll_pkg::chan_t    out_blue,
    output crll_pkg::chan_t    out_alpha
);

    logic                                   vld_p_reg;
    logic                                   vld_o_reg;
    crll_pkg::chan_t                        base_reg [crll_pkg::NUM_CHAN];
    logic signed [crll_pkg::PROD_W-1:0]     prod_reg [crll_pkg::NUM_CHAN];
    crll_pkg::chan_t                        res_reg  [crll_pkg::NUM_CHAN];

    logic signed [crll_pkg::PROD_W-1:0]     prod_next [crll_pkg::NUM_CHAN];
    crll_pkg::chan_t                        base_next [crll_pkg::NUM_CHAN];
    crll_pkg::chan_t                        res_next  [crll_pkg::NUM_CHAN];

    // red in the top byte, alpha in the bottom
    always_comb
    begin
        logic signed [crll_pkg::CHAN_W:0]     d;
        logic signed [crll_pkg::AGE_W-1:0]    f;
        logic signed [crll_pkg::PROD_W-1:0]   sum;
        f = $signed({1'b0, in_frac});
        for (int c = 0; c < crll_pkg::NUM_CHAN; c++)
        begin
            base_next[c] = in_from[crll_pkg::CHAN_W*(crll_pkg::NUM_CHAN-1-c) +: crll_pkg::CHAN_W];
            d = $signed({1'b0, in_to[crll_pkg::CHAN_W*(crll_pkg::NUM_CHAN-1-c) +:
                                     crll_pkg::CHAN_W]})
                - $signed({1'b0, base_next[c]});
            prod_next[c] = d * f;
            sum = $signed({{(crll_pkg::PROD_W-crll_pkg::SUM_W){1'b0}}, base_reg[c],
                           {crll_pkg::FRAC_W{1'b0}}}) + prod_reg[c];
            res_next[c] = sum[crll_pkg::SUM_W-1:crll_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg <= 1'b0;
            vld_o_reg <= 1'b0;
        end
        else
        begin
            vld_p_reg <= in_valid;
            vld_o_reg <= vld_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < crll_pkg::NUM_CHAN; c++)
        begin
            base_reg[c] <= base_next[c];
            prod_reg[c] <= prod_next[c];
            res_reg[c]  <= res_next[c];
        end
    end

    assign out_valid = vld_o_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];

endmodule

// File: rtl/core/color_ramp_lerp_lookup.sv
// color_ramp_lerp_lookup: top level of the particle color ramp sampler
// depends on crll_pkg, crll_age_div, crll_ramp_mem and crll_lerp
//
//  channel   ports                                                  handshake
//  request   req_type entry_index entry_color life_left life_total  start / busy
//  result    red green blue alpha                                   done (one cycle)
//  config    cfg_data (ramp_entries)                                cfg_valid / cfg_ready
//
// one item enters per cycle; busy stays low and cfg_ready stays high
// a shade item's result shows with done after it is accepted and passes, in order:
// input register, four divider stages, age scaling, memory read, two blend stages
// write items run down the same pipeline and update the ramp at the read stage, in order
// reset clears the valid bits and sets ramp_entries to 256; the ramp memory is not cleared
// the receiver cannot stall, so nothing in the pipeline ever waits
module color_ramp_lerp_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [7:0]                    entry_index,
    input  logic [31:0]                   entry_color,
    input  logic [15:0]                   life_left,
    input  logic [15:0]                   life_total,
    output logic                          done,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic [7:0]                    alpha,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [crll_pkg::CFG_W-1:0]    cfg_data
);

    crll_pkg::cfg_t     ramp_entries_reg;
    crll_pkg::nuse_t    n_use;
    crll_pkg::addr_t    last;

    crll_pkg::item_t    in_item;
    logic               div_valid;
    crll_pkg::age_t     div_age;
    crll_pkg::item_t    div_item;

    logic               vld_m_reg;
    crll_pkg::item_t    item_m_reg;
    crll_pkg::pos_t     pos_reg;
    crll_pkg::mul_t     mul;

    crll_pkg::addr_t    k;
    logic               at_end;
    crll_pkg::addr_t    addr_a;
    crll_pkg::addr_t    addr_b;
    crll_pkg::frac_t    frac_sel;

    logic               vld_r_reg;
    crll_pkg::frac_t    frac_r_reg;
    crll_pkg::color_t   from_color;
    crll_pkg::color_t   to_color;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_entries_reg <= crll_pkg::cfg_t'(crll_pkg::RAMP_DEPTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            ramp_entries_reg <= cfg_data;
        end
    end

    // entries in use, clamped to 1..depth
    always_comb
    begin
        if (ramp_entries_reg == '0)
        begin
            n_use = crll_pkg::nuse_t'(1);
        end
        else if (32'(ramp_entries_reg) > 32'(crll_pkg::RAMP_DEPTH))
        begin
            n_use = crll_pkg::nuse_t'(crll_pkg::RAMP_DEPTH);
        end
        else
        begin
            n_use = crll_pkg::nuse_t'(ramp_entries_reg);
        end
        last = crll_pkg::addr_t'(n_use - crll_pkg::nuse_t'(1));
    end

    always_comb
    begin
        in_item.shade = (req_type == crll_pkg::REQ_SHADE);
        in_item.wr_en = (req_type == crll_pkg::REQ_WRITE)
                        && (32'(entry_index) < 32'(crll_pkg::RAMP_DEPTH));
        in_item.addr  = crll_pkg::addr_t'(entry_index);
        in_item.color = entry_color;
    end

    crll_age_div u_age_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_left   (life_left),
        .in_total  (life_total),
        .in_item   (in_item),
        .out_valid (div_valid),
        .out_age   (div_age),
        .out_item  (div_item)
    );

    assign mul = crll_pkg::mul_t'(div_age) * crll_pkg::mul_t'(last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
        end
        else
        begin
            vld_m_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_m_reg <= div_item;
        pos_reg    <= crll_pkg::pos_t'(mul);
    end

    // at or past the last entry both reads hit it and the fraction drops
    always_comb
    begin
        k      = pos_reg[crll_pkg::POS_W-1:crll_pkg::FRAC_W];
        at_end = (k >= last);
        if (at_end)
        begin
            addr_a   = last;
            addr_b   = last;
            frac_sel = '0;
        end
        else
        begin
            addr_a   = k;
            addr_b   = k + crll_pkg::addr_t'(1);
            frac_sel = pos_reg[crll_pkg::FRAC_W-1:0];
        end
    end

    crll_ramp_mem u_ramp_mem (
        .clk       (clk),
        .wr_en     (vld_m_reg && item_m_reg.wr_en),
        .wr_addr   (item_m_reg.addr),
        .wr_data   (item_m_reg.color),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (from_color),
        .rd_data_b (to_color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_r_reg <= 1'b0;
        end
        else
        begin
            vld_r_reg <= vld_m_reg && item_m_reg.shade;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_r_reg <= frac_sel;
    end

    crll_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_r_reg),
        .in_frac   (frac_r_reg),
        .in_from   (from_color),
        .in_to     (to_color),
        .out_valid (done),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue),
        .out_alpha (alpha)
    );

`ifndef SYNTHESIS
    a_done_from_shade: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && req_type == crll_pkg::REQ_SHADE, crll_pkg::LATENCY))
        else $error("result strobe without a matching shade item");

    a_shade_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == crll_pkg::REQ_SHADE) |-> ##(crll_pkg::LATENCY) done)
        else $error("shade item produced no result");

    a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_m_reg && item_m_reg.shade) |->
            (addr_b <= last) && (addr_a <= addr_b) && (addr_b - addr_a <= crll_pkg::addr_t'(1)))
        else $error("ramp read addresses outside the entries in use");
`endif

endmodule
